// ===== src/owtr_pkg.sv =====
`timescale 1ns / 1ps

package owtr_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam int CONV_WAIT_W   = 20;
  localparam int RESET_LOW_W   = 10;
  localparam int READ_SAMPLE_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_CONV_WAIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE = 2'd2;

  localparam logic [CONV_WAIT_W-1:0]   CONV_WAIT_DEFAULT   = 20'd750000;
  localparam logic [RESET_LOW_W-1:0]   RESET_LOW_DEFAULT   = 10'd480;
  localparam logic [READ_SAMPLE_W-1:0] READ_SAMPLE_DEFAULT = 6'd15;

  localparam int PRESENCE_SAMPLE_US = 60;
  localparam int RESET_REST_US      = 420;
  localparam int SLOT_US            = 62;
  localparam int WRITE_HOLD_END     = 60;

  localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_PAD = 8'hBE;

  localparam logic [2:0] STEP_CONVERT  = 3'd1;
  localparam logic [2:0] STEP_CONV     = 3'd2;
  localparam logic [2:0] STEP_READ_PAD = 3'd3;
  localparam logic [2:0] STEP_LSB      = 3'd4;
  localparam logic [2:0] STEP_MSB      = 3'd5;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_RST_LOW  = 7'b0000010,
    PH_RST_WAIT = 7'b0000100,
    PH_RST_REST = 7'b0001000,
    PH_WRITE    = 7'b0010000,
    PH_CONV     = 7'b0100000,
    PH_READ     = 7'b1000000
  } phase_t;

  // result word, lowest bit last
  typedef struct packed {
    logic [3:0]         pad;
    logic signed [15:0] temperature_sixteenths;
    logic               no_presence;
    logic               done_res;
    logic               busy_res;
    logic               pull_low;
  } out_item_t;

endpackage

// ===== src/one_wire_temperature_reader.sv =====
`timescale 1ns / 1ps

// One-wire bus master that reads a temperature sensor. Each input request is either a
// one-microsecond tick (tuser 0) or a start (tuser 1), with the sampled bus level in
// tdata bit 0; every request produces exactly one result showing the bus drive, busy,
// a done pulse, a no-presence error and the signed raw reading in sixteenths of a
// degree. The sequencer state and the result register are both updated at the
// accepting edge, and a new request is taken every cycle while the result register is
// empty or being drained. Configuration must be written through the cfg port only while
// no sequence is running; the block itself does not enforce this.
module one_wire_temperature_reader #(
  parameter int TIMER_BITS = 20
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [owtr_pkg::IN_TDATA_W-1:0]      s_tdata,   // line_level
  input  logic                                 s_tuser,   // req_type
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // pull_low, busy_res, done_res, no_presence, temperature_sixteenths
  output logic [owtr_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                 cfg_we,
  input  logic [owtr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [owtr_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import owtr_pkg::*;

  localparam int CW = (TIMER_BITS > CONV_WAIT_W) ? TIMER_BITS : CONV_WAIT_W;
  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};
  localparam logic [CW-1:0] TMAX_EXT = CW'(TMAX);

  logic [CONV_WAIT_W-1:0]   conversion_wait_us;
  logic [RESET_LOW_W-1:0]   reset_low_us;
  logic [READ_SAMPLE_W-1:0] read_sample_us;

  phase_t                  phase, phase_next;
  logic [TIMER_BITS-1:0]   phase_timer, phase_timer_next;
  logic [2:0]              bit_index, bit_index_next;
  logic [2:0]              byte_index, byte_index_next;
  logic [7:0]              shift_byte, shift_byte_next;
  logic [15:0]             reading, reading_next;
  out_item_t               out_item, out_item_next;

  logic                    accept;
  logic                    line;
  logic [TIMER_BITS-1:0]   t_inc;
  logic [RESET_LOW_W-1:0]  rst_lim;
  logic [READ_SAMPLE_W-1:0] smp;
  logic [READ_SAMPLE_W:0]  slot_end;
  logic [CW-1:0]           conv_lim;
  logic [7:0]              shifted;
  logic [2:0]              bit_inc;
  logic [2:0]              byte_inc;
  logic                    done, nopres;
  logic [15:0]             temp;
  logic                    drive;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign line     = s_tdata[0];
  assign m_tdata  = out_item;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      conversion_wait_us <= CONV_WAIT_DEFAULT;
      reset_low_us       <= RESET_LOW_DEFAULT;
      read_sample_us     <= READ_SAMPLE_DEFAULT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CONV_WAIT:   conversion_wait_us <= cfg_data[CONV_WAIT_W-1:0];
        CFG_RESET_LOW:   reset_low_us       <= cfg_data[RESET_LOW_W-1:0];
        CFG_READ_SAMPLE: read_sample_us     <= cfg_data[READ_SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    t_inc    = (phase_timer == TMAX) ? phase_timer : phase_timer + 1'b1;
    rst_lim  = (reset_low_us == '0) ? RESET_LOW_W'(1) : reset_low_us;
    smp      = (read_sample_us == '0) ? READ_SAMPLE_W'(1) : read_sample_us;
    slot_end = ((READ_SAMPLE_W + 1)'(smp) + 1'b1 > (READ_SAMPLE_W + 1)'(SLOT_US)) ?
               (READ_SAMPLE_W + 1)'(smp) + 1'b1 : (READ_SAMPLE_W + 1)'(SLOT_US);
    conv_lim = (CW'(conversion_wait_us) > TMAX_EXT) ? TMAX_EXT : CW'(conversion_wait_us);
    bit_inc  = bit_index + 3'd1;
    byte_inc = byte_index + 3'd1;
    shifted  = shift_byte;

    phase_next       = phase;
    phase_timer_next = phase_timer;
    bit_index_next   = bit_index;
    byte_index_next  = byte_index;
    shift_byte_next  = shift_byte;
    reading_next     = reading;
    done             = 1'b0;
    nopres           = 1'b0;
    temp             = '0;

    if (s_tuser) begin
      if (phase == PH_IDLE) begin
        phase_next       = PH_RST_LOW;
        phase_timer_next = '0;
        bit_index_next   = '0;
        byte_index_next  = '0;
        shift_byte_next  = '0;
        reading_next     = '0;
      end
    end else if (phase != PH_IDLE) begin
      phase_timer_next = t_inc;
      unique case (phase)
        PH_RST_LOW: begin
          if (t_inc >= TIMER_BITS'(rst_lim)) begin
            phase_next       = PH_RST_WAIT;
            phase_timer_next = '0;
          end
        end
        PH_RST_WAIT: begin
          if (t_inc >= TIMER_BITS'(PRESENCE_SAMPLE_US)) begin
            phase_timer_next = '0;
            if (line) begin
              phase_next = PH_IDLE;
              done       = 1'b1;
              nopres     = 1'b1;
            end else begin
              phase_next = PH_RST_REST;
            end
          end
        end
        PH_RST_REST: begin
          if (t_inc >= TIMER_BITS'(RESET_REST_US)) begin
            phase_next       = PH_WRITE;
            phase_timer_next = '0;
            bit_index_next   = '0;
            shift_byte_next  = CMD_SKIP_ROM;
          end
        end
        PH_WRITE: begin
          if (t_inc >= TIMER_BITS'(SLOT_US)) begin
            phase_timer_next = '0;
            shift_byte_next  = {1'b0, shift_byte[7:1]};
            bit_index_next   = bit_inc;
            if (bit_inc == '0) begin
              byte_index_next = byte_inc;
              if (byte_inc == STEP_CONVERT) begin
                shift_byte_next = CMD_CONVERT;
              end else if (byte_inc == STEP_CONV) begin
                phase_next = PH_CONV;
              end else if (byte_inc == STEP_READ_PAD) begin
                shift_byte_next = CMD_READ_PAD;
              end else begin
                byte_index_next = STEP_LSB;
                phase_next      = PH_READ;
                shift_byte_next = '0;
              end
            end
          end
        end
        PH_CONV: begin
          if (CW'(t_inc) >= conv_lim) begin
            phase_next       = PH_RST_LOW;
            phase_timer_next = '0;
          end
        end
        PH_READ: begin
          if (t_inc == TIMER_BITS'(smp)) begin
            shifted = {line, shift_byte[7:1]};
          end
          shift_byte_next = shifted;
          if (t_inc >= TIMER_BITS'(slot_end)) begin
            phase_timer_next = '0;
            bit_index_next   = bit_inc;
            if (bit_inc == '0) begin
              if (byte_index == STEP_LSB) begin
                reading_next    = {8'h00, shifted};
                byte_index_next = STEP_MSB;
                shift_byte_next = '0;
              end else begin
                reading_next = {shifted, reading[7:0]};
                phase_next   = PH_IDLE;
                done         = 1'b1;
                temp         = {shifted, reading[7:0]};
              end
            end
          end
        end
        default: begin
          phase_next       = PH_IDLE;
          phase_timer_next = '0;
        end
      endcase
    end

    unique case (phase_next)
      PH_RST_LOW: drive = 1'b1;
      PH_WRITE: begin
        if (phase_timer_next == '0) begin
          drive = 1'b1;
        end else if (phase_timer_next <= TIMER_BITS'(WRITE_HOLD_END)) begin
          drive = !shift_byte_next[0];
        end else begin
          drive = 1'b0;
        end
      end
      PH_READ: drive = (phase_timer_next == '0);
      default: drive = 1'b0;
    endcase

    out_item_next.pad                    = '0;
    out_item_next.temperature_sixteenths = temp;
    out_item_next.no_presence            = nopres;
    out_item_next.done_res               = done;
    out_item_next.busy_res               = (phase_next != PH_IDLE);
    out_item_next.pull_low               = drive;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      phase_timer <= '0;
      bit_index   <= '0;
      byte_index  <= '0;
      shift_byte  <= '0;
      reading     <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (accept) begin
        phase       <= phase_next;
        phase_timer <= phase_timer_next;
        bit_index   <= bit_index_next;
        byte_index  <= byte_index_next;
        shift_byte  <= shift_byte_next;
        reading     <= reading_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item <= out_item_next;
    end
  end

endmodule

// ===== src/owtr_checker.sv =====
`timescale 1ns / 1ps

module owtr_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [owtr_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import owtr_pkg::*;

  out_item_t item;
  assign item = m_tdata;

  // a finished sequence never reports busy in the same result
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && item.done_res |-> !item.busy_res)
    else $error("done result still busy");

  a_nopres_with_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && item.no_presence |-> item.done_res)
    else $error("no_presence without done");

  a_temp_only_on_good_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && item.temperature_sixteenths != '0 |-> item.done_res && !item.no_presence)
    else $error("temperature outside a successful done");

  a_drive_only_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && item.pull_low |-> item.busy_res)
    else $error("bus driven while idle");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind one_wire_temperature_reader owtr_checker u_owtr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== dv/owtr_checker.sv =====
`timescale 1ns / 1ps

module owtr_scoreboard (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [owtr_pkg::IN_TDATA_W-1:0]  s_tdata,   // line_level
  input  logic                             s_tuser,   // req_type
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  // pull_low, busy_res, done_res, no_presence, temperature_sixteenths
  input  logic [owtr_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                             cfg_we,
  input  logic [owtr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [owtr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               mismatches,
  output int                               outstanding
);

  import owtr_pkg::*;

  localparam int TIMER_BITS = 20;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  phase_t                   seq_phase;
  logic [TIMER_BITS-1:0]    slot_timer;
  logic [2:0]               bit_cnt;
  logic [2:0]               step_cnt;
  logic [7:0]               shifter;
  logic [15:0]              raw_word;

  logic [CONV_WAIT_W-1:0]   conv_wait;
  logic [RESET_LOW_W-1:0]   reset_low;
  logic [READ_SAMPLE_W-1:0] read_sample;

  out_item_t bus_reports[$];
  out_item_t want;
  out_item_t got;

  function automatic logic bus_pulled_low();
    case (seq_phase)
      PH_RST_LOW: return 1'b1;
      PH_WRITE: begin
        if (slot_timer == 0) return 1'b1;
        if (slot_timer <= WRITE_HOLD_END) return ~shifter[0];
        return 1'b0;
      end
      PH_READ: return slot_timer == 0;
      default: return 1'b0;
    endcase
  endfunction

  task automatic load_command(input logic [7:0] cmd);
    seq_phase = PH_WRITE;
    slot_timer = '0;
    bit_cnt = '0;
    shifter = cmd;
  endtask

  // one request in, one bus report out
  task automatic advance_bus_master(input logic start, input logic line);
    out_item_t rep;
    int low_len;
    int smp;
    int slot_end;
    rep = '0;
    low_len = (reset_low == 0) ? 1 : int'(reset_low);
    smp = (read_sample == 0) ? 1 : int'(read_sample);
    slot_end = (smp + 1 > SLOT_US) ? smp + 1 : SLOT_US;
    if (start) begin
      if (seq_phase == PH_IDLE) begin
        seq_phase = PH_RST_LOW;
        slot_timer = '0;
        bit_cnt = '0;
        step_cnt = '0;
        shifter = '0;
        raw_word = '0;
      end
    end else if (seq_phase != PH_IDLE) begin
      if (slot_timer != TIMER_MAX) slot_timer = slot_timer + 1'b1;
      case (seq_phase)
        PH_RST_LOW: begin
          if (slot_timer >= low_len) begin
            seq_phase = PH_RST_WAIT;
            slot_timer = '0;
          end
        end
        PH_RST_WAIT: begin
          if (slot_timer >= PRESENCE_SAMPLE_US) begin
            slot_timer = '0;
            if (line) begin
              seq_phase = PH_IDLE;
              rep.done_res = 1'b1;
              rep.no_presence = 1'b1;
            end else begin
              seq_phase = PH_RST_REST;
            end
          end
        end
        PH_RST_REST: begin
          if (slot_timer >= RESET_REST_US) load_command(CMD_SKIP_ROM);
        end
        PH_WRITE: begin
          if (slot_timer >= SLOT_US) begin
            slot_timer = '0;
            shifter = shifter >> 1;
            bit_cnt = bit_cnt + 1'b1;
            if (bit_cnt == 0) begin
              step_cnt = step_cnt + 1'b1;
              if (step_cnt == STEP_CONVERT) begin
                load_command(CMD_CONVERT);
              end else if (step_cnt == STEP_CONV) begin
                seq_phase = PH_CONV;
              end else if (step_cnt == STEP_READ_PAD) begin
                load_command(CMD_READ_PAD);
              end else begin
                step_cnt = STEP_LSB;
                seq_phase = PH_READ;
                shifter = '0;
              end
            end
          end
        end
        PH_CONV: begin
          if (slot_timer >= conv_wait) begin
            seq_phase = PH_RST_LOW;
            slot_timer = '0;
          end
        end
        PH_READ: begin
          if (slot_timer == smp) shifter = {line, shifter[7:1]};
          if (slot_timer >= slot_end) begin
            slot_timer = '0;
            bit_cnt = bit_cnt + 1'b1;
            if (bit_cnt == 0) begin
              if (step_cnt == STEP_LSB) begin
                raw_word = {8'h00, shifter};
                step_cnt = STEP_MSB;
                shifter = '0;
              end else begin
                raw_word = {shifter, raw_word[7:0]};
                seq_phase = PH_IDLE;
                rep.done_res = 1'b1;
                rep.temperature_sixteenths = raw_word;
              end
            end
          end
        end
        default: begin
          seq_phase = PH_IDLE;
          slot_timer = '0;
        end
      endcase
    end
    rep.pull_low = bus_pulled_low();
    rep.busy_res = seq_phase != PH_IDLE;
    bus_reports.push_back(rep);
  endtask

  task automatic compare_field(input string field, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", field, exp_val, act_val);
      mismatches++;
    end
  endtask

  // sampled mid-cycle, so the values seen are the ones at the next rising edge
  always @(negedge clk) begin
    if (rst) begin
      seq_phase = PH_IDLE;
      slot_timer = '0;
      bit_cnt = '0;
      step_cnt = '0;
      shifter = '0;
      raw_word = '0;
      conv_wait = CONV_WAIT_DEFAULT;
      reset_low = RESET_LOW_DEFAULT;
      read_sample = READ_SAMPLE_DEFAULT;
      mismatches = 0;
      bus_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CONV_WAIT:   conv_wait = cfg_data[CONV_WAIT_W-1:0];
          CFG_RESET_LOW:   reset_low = cfg_data[RESET_LOW_W-1:0];
          CFG_READ_SAMPLE: read_sample = cfg_data[READ_SAMPLE_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) advance_bus_master(s_tuser, s_tdata[0]);
      if (m_tvalid && m_tready) begin
        got = out_item_t'(m_tdata);
        if (bus_reports.size() == 0) begin
          $error("result with no request outstanding: %h", m_tdata);
          mismatches++;
        end else begin
          want = bus_reports.pop_front();
          compare_field("pull_low", int'(want.pull_low), int'(got.pull_low));
          compare_field("busy_res", int'(want.busy_res), int'(got.busy_res));
          compare_field("done_res", int'(want.done_res), int'(got.done_res));
          compare_field("no_presence", int'(want.no_presence), int'(got.no_presence));
          compare_field("temperature_sixteenths", int'(want.temperature_sixteenths),
                        int'(got.temperature_sixteenths));
        end
      end
    end
    outstanding = bus_reports.size();
  end

endmodule

// ===== dv/one_wire_temperature_reader_tb.sv =====
`timescale 1ns / 1ps

module one_wire_temperature_reader_tb;

  import owtr_pkg::*;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [IN_TDATA_W-1:0]    s_tdata;
  logic                     s_tuser;
  logic                     m_tvalid;
  logic                     m_tready;
  logic [OUT_TDATA_W-1:0]   m_tdata;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;

  int mismatches;
  int outstanding;
  int quiet_cycles = 0;
  int gap_odds = 0;
  bit calm = 1'b0;

  logic [CONV_WAIT_W-1:0]   conv_now;
  logic [RESET_LOW_W-1:0]   low_now;
  logic [READ_SAMPLE_W-1:0] smp_now;

  one_wire_temperature_reader #(.TIMER_BITS(20)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  owtr_scoreboard reading_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic put_request(input logic req, input logic line);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {{(IN_TDATA_W-1){1'b0}}, line};
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic program_timing(input logic [CONV_WAIT_W-1:0] conv,
                                input logic [RESET_LOW_W-1:0] low,
                                input logic [READ_SAMPLE_W-1:0] smp);
    logic [CFG_DATA_W-RESET_LOW_W-1:0]   low_junk;
    logic [CFG_DATA_W-READ_SAMPLE_W-1:0] smp_junk;
    low_junk = (CFG_DATA_W-RESET_LOW_W)'($urandom);
    smp_junk = (CFG_DATA_W-READ_SAMPLE_W)'($urandom);
    conv_now = conv;
    low_now = low;
    smp_now = smp;
    cfg_we <= 1'b1;
    cfg_index <= CFG_CONV_WAIT;
    cfg_data <= conv;
    @(posedge clk);
    cfg_index <= CFG_RESET_LOW;
    cfg_data <= {low_junk, low};
    @(posedge clk);
    cfg_index <= CFG_READ_SAMPLE;
    cfg_data <= {smp_junk, smp};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one temperature read; the sensor answers presence and read slots from a target word
  task automatic run_sequence(input bit first_ok, input bit second_ok);
    int low_len;
    int smp;
    int slot_end;
    int conv_len;
    int first_pt;
    int second_pt;
    int read_pt;
    int last_tick;
    int mode;
    int k;
    int ofs;
    logic [15:0] word;
    logic line;
    low_len = (low_now == 0) ? 1 : int'(low_now);
    smp = (smp_now == 0) ? 1 : int'(smp_now);
    slot_end = (smp + 1 > SLOT_US) ? smp + 1 : SLOT_US;
    conv_len = (conv_now == 0) ? 1 : int'(conv_now);
    first_pt = low_len + PRESENCE_SAMPLE_US;
    second_pt = first_pt + RESET_REST_US + 16 * SLOT_US + conv_len + low_len
                + PRESENCE_SAMPLE_US;
    read_pt = second_pt + RESET_REST_US + 16 * SLOT_US;
    last_tick = !first_ok ? first_pt : (!second_ok ? second_pt : read_pt + 16 * slot_end);
    mode = $urandom_range(0, 2);
    case ($urandom_range(0, 5))
      0: word = 16'h8000;
      1: word = 16'h7FFF;
      2: word = 16'hFFFF;
      3: word = 16'h0000;
      default: word = 16'($urandom);
    endcase
    put_request(REQ_START, 1'($urandom_range(0, 1)));
    for (int t = 1; t <= last_tick; t++) begin
      // stray start while busy
      if ($urandom_range(0, 199) == 0) put_request(REQ_START, 1'($urandom_range(0, 1)));
      case (mode)
        0: line = 1'($urandom_range(0, 1));
        1: line = 1'b0;
        default: line = 1'b1;
      endcase
      if (t == first_pt) begin
        line = first_ok ? 1'b0 : 1'b1;
      end else if (t == second_pt) begin
        line = second_ok ? 1'b0 : 1'b1;
      end else if (t > read_pt) begin
        k = (t - read_pt - 1) / slot_end;
        ofs = t - read_pt - k * slot_end;
        if (ofs == smp) line = word[k];
      end
      put_request(REQ_TICK, line);
    end
    repeat ($urandom_range(1, 3)) put_request(REQ_TICK, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      m_tready <= 1'b1;
      repeat (($urandom_range(0, 5) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 40))
        @(posedge clk);
      if (!calm) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end
  end

  always @(negedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser <= REQ_TICK;
    s_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_CONV_WAIT;
    cfg_data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // zero timing values behave as one
    program_timing('0, '0, '0);
    put_request(REQ_TICK, 1'b0);
    put_request(REQ_TICK, 1'b1);
    put_request(REQ_START, 1'b1);
    put_request(REQ_START, 1'b0);
    for (int i = 0; i < 60; i++) put_request(REQ_TICK, i[0]);
    // bus stays high at the presence sample
    put_request(REQ_TICK, 1'b1);
    put_request(REQ_TICK, 1'b0);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      calm = (ph == 3);
      case ($urandom_range(0, 2))
        0: gap_odds = 0;
        1: gap_odds = 4;
        default: gap_odds = 16;
      endcase
      if (calm) gap_odds = 0;
      case (ph)
        // shortest timing: both commands and the conversion wait, no sensor at the second reset
        0: begin
          program_timing('0, '0, '0);
          run_sequence(1'b1, 1'b0);
        end
        1: begin
          program_timing(CONV_WAIT_W'(1), RESET_LOW_W'(1), '1);
          run_sequence(1'b0, 1'b1);
        end
        // longest conversion wait: only runs that stop at the first presence check
        2: begin
          program_timing('1, RESET_LOW_W'(2), READ_SAMPLE_W'(1));
          run_sequence(1'b0, 1'b1);
        end
        default: begin
          program_timing(CONV_WAIT_W'($urandom_range(0, 400)),
                         RESET_LOW_W'($urandom_range(1, 20)),
                         READ_SAMPLE_W'($urandom_range(1, 63)));
          run_sequence(1'b0, 1'b1);
        end
      endcase
      settle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
